/* sv/upe_pkg.sv */
// Shared types, character codes and helpers for the URL percent escaper.
package upe_pkg;

  // URL part selected by the mode register
  typedef enum logic [1:0] {
    PART_PATH     = 2'd0,
    PART_USER     = 2'd1,
    PART_QUERY    = 2'd2,
    PART_FRAGMENT = 2'd3
  } part_t;

  localparam logic [7:0] CH_PERCENT = 8'h25;

  // Queue between classifier and expander
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  typedef struct packed {
    logic [7:0] data;
    logic       esc;   // emit as %XY
  } entry_t;

  // Upper-case hex digit for one nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'h0, n};
    end else begin
      r = 8'h37 + {4'h0, n};
    end
    return r;
  endfunction

endpackage

/* sv/upe_in_if.sv */
// Input request channel: one raw byte per request.
interface upe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

/* sv/upe_out_if.sv */
// Output request channel: one encoded character per request.
interface upe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

/* sv/upe_front.sv */
// Front end: mode register, input handshake and escape classification.
module upe_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_wdata,
  upe_in_if.sink          in_req,
  output logic            push_valid,
  input  logic            push_ready,
  output upe_pkg::entry_t push_data
);

  upe_pkg::part_t part_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= upe_pkg::PART_PATH;
    end else if (cfg_we) begin
      part_r <= upe_pkg::part_t'(cfg_wdata);
    end
  end

  logic [7:0] b;
  logic       is_alnum;
  logic       is_mark;
  logic       is_resv;
  logic       resv_esc;
  logic       esc;

  assign b = in_req.in_byte;

  // 0-9, A-Z, a-z
  assign is_alnum = (b >= 8'h30 && b <= 8'h39) ||
                    (b >= 8'h41 && b <= 8'h5A) ||
                    (b >= 8'h61 && b <= 8'h7A);
  // - . _ ~
  assign is_mark  = (b == 8'h2D) || (b == 8'h2E) || (b == 8'h5F) || (b == 8'h7E);
  // $ & + , / : ; = ? @
  assign is_resv  = (b == 8'h24) || (b == 8'h26) || (b == 8'h2B) || (b == 8'h2C) ||
                    (b == 8'h2F) || (b == 8'h3A) || (b == 8'h3B) || (b == 8'h3D) ||
                    (b == 8'h3F) || (b == 8'h40);

  always_comb begin
    unique case (part_r)
      upe_pkg::PART_PATH:     resv_esc = (b == 8'h3F);
      upe_pkg::PART_USER:     resv_esc = (b == 8'h40) || (b == 8'h2F) || (b == 8'h3A);
      upe_pkg::PART_QUERY:    resv_esc = 1'b1;
      upe_pkg::PART_FRAGMENT: resv_esc = 1'b0;
      default:                resv_esc = 1'b0;
    endcase
  end

  always_comb begin
    priority if (is_alnum || is_mark) begin
      esc = 1'b0;
    end else if (is_resv) begin
      esc = resv_esc;
    end else begin
      esc = 1'b1;
    end
  end

  assign in_req.ready   = push_ready;
  assign push_valid     = in_req.valid;
  assign push_data.data = b;
  assign push_data.esc  = esc;

endmodule

/* sv/upe_fifo.sv */
// Short queue of classified bytes between front and back end.
module upe_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  upe_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output upe_pkg::entry_t pop_data
);

  upe_pkg::entry_t mem_r [upe_pkg::QDepth];

  logic [upe_pkg::QAw-1:0] wptr_r, wptr_nxt;
  logic [upe_pkg::QAw-1:0] rptr_r, rptr_nxt;
  logic [upe_pkg::QAw:0]   cnt_r,  cnt_nxt;
  logic                    do_push, do_pop;

  assign push_ready = (cnt_r != (upe_pkg::QAw+1)'(upe_pkg::QDepth));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rptr_r];

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

/* sv/upe_back.sv */
// Back end: expands each queued byte into one character or a %XY triple.
module upe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  upe_pkg::entry_t pop_data,
  upe_out_if.source       out_req
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HI   = 3'b010,
    PH_LO   = 3'b100
  } phase_t;

  phase_t     ph_r, ph_nxt;
  logic [7:0] cur_r, cur_nxt;
  logic       ovld_r, ovld_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       olast_r, olast_nxt;
  logic       advance;

  // output register can take a new character
  assign advance   = !ovld_r || out_req.ready;
  assign pop_ready = advance && (ph_r == PH_IDLE);

  always_comb begin
    ph_nxt    = ph_r;
    cur_nxt   = cur_r;
    ovld_nxt  = ovld_r;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    if (advance) begin
      unique case (ph_r)
        PH_HI: begin
          ovld_nxt  = 1'b1;
          obyte_nxt = upe_pkg::hex_digit(cur_r[7:4]);
          olast_nxt = 1'b0;
          ph_nxt    = PH_LO;
        end
        PH_LO: begin
          ovld_nxt  = 1'b1;
          obyte_nxt = upe_pkg::hex_digit(cur_r[3:0]);
          olast_nxt = 1'b1;
          ph_nxt    = PH_IDLE;
        end
        PH_IDLE: begin
          ovld_nxt = pop_valid;
          if (pop_valid) begin
            cur_nxt = pop_data.data;
            if (pop_data.esc) begin
              obyte_nxt = upe_pkg::CH_PERCENT;
              olast_nxt = 1'b0;
              ph_nxt    = PH_HI;
            end else begin
              obyte_nxt = pop_data.data;
              olast_nxt = 1'b1;
            end
          end
        end
        default: begin
          ph_nxt   = PH_IDLE;
          ovld_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      ovld_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign out_req.valid    = ovld_r;
  assign out_req.out_byte = obyte_r;
  assign out_req.run_last = olast_r;

endmodule

/* sv/url_percent_escape.sv */
// Top level of the URL percent escaper.
//
// in_req carries one raw byte per request (valid/ready). out_req carries
// the encoded string one character per request; run_last marks the last
// character produced by an input byte. A byte that passes unchanged gives
// one character; any other byte gives '%' and two upper-case hex digits.
// cfg_we/cfg_wdata write the URL part register (0 path, 1 user info,
// 2 query component, 3 fragment); write it only while the block is idle.
// An accepted byte goes into the queue; the expander pops it and puts
// each character in the single output register, one per cycle while
// out_req.ready is high. No new byte is popped until the last hex digit
// of an escaped byte. A four-entry queue between the classifier and the
// expander keeps input accepted while the output stalls, until it fills.
// Reset (rst_n low, synchronous) empties the queue and output register and
// sets the URL part to path. While out_req.ready is low the current
// character holds on out_req and nothing is lost.
module url_percent_escape (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [1:0] cfg_wdata,
  upe_in_if.sink    in_req,
  upe_out_if.source out_req
);

  logic            push_valid, push_ready;
  upe_pkg::entry_t push_data;
  logic            pop_valid, pop_ready;
  upe_pkg::entry_t pop_data;

  upe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_req     (in_req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  upe_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  upe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_req   (out_req)
  );

endmodule
